@@ src/baeh_pkg.sv @@
// baeh_pkg: shared types, codes and constant tables of the binned alignment error histogram
// used by the front, queue, back and top level; depends on nothing
`timescale 1ns / 1ps

package baeh_pkg;

	localparam int NUM_BINS_DEF = 1024;
	localparam int VAR_PER_BIN = 48;

	// symbol codes
	localparam logic [2:0] BASE_N = 3'd4;
	localparam logic [2:0] BASE_GAP = 3'd5;
	localparam logic [2:0] BASE_X = 3'd6;
	localparam logic [2:0] BASE_NONE = 3'd7;

	// result classes
	localparam logic [2:0] CLS_MATCH = 3'd0;
	localparam logic [2:0] CLS_SUB = 3'd1;
	localparam logic [2:0] CLS_DEL = 3'd2;
	localparam logic [2:0] CLS_INS = 3'd3;
	localparam logic [2:0] CLS_SKIP = 3'd4;
	localparam logic [2:0] CLS_RANGE = 3'd5;

	// job kinds in the queue
	localparam logic [1:0] JOB_READ = 2'd0;
	localparam logic [1:0] JOB_ACC = 2'd1;
	localparam logic [1:0] JOB_SKIP = 2'd2;
	localparam logic [1:0] JOB_NONE = 2'd3;

	// operations
	localparam logic OP_ACC = 1'b0;
	localparam logic OP_READ = 1'b1;

	// counter selects
	localparam logic [5:0] SEL_TOTAL = 6'd0;
	localparam logic [5:0] SEL_WRONG = 6'd1;
	localparam logic [5:0] SEL_DEL = 6'd2;
	localparam logic [5:0] SEL_INS = 6'd3;
	localparam logic [5:0] SEL_SUB = 6'd4;
	localparam logic [5:0] SEL_PSUM = 6'd5;
	localparam logic [5:0] SEL_QCNT = 6'd6;
	localparam logic [5:0] SEL_VAR_FIRST = 6'd7;
	localparam logic [5:0] SEL_VAR_LAST = 6'd54;
	localparam logic [5:0] SEL_GLB_FIRST = 6'd55;
	localparam logic [5:0] SEL_GLB_LAST = 6'd60;

	// variant table offsets inside one bin row
	localparam logic [5:0] VAR_INS_BASE = 6'd36;
	localparam logic [5:0] VAR_DEL_BASE = 6'd42;

	// register indexes
	localparam logic [2:0] REG_BIN_SIZE = 3'd0;
	localparam logic [2:0] REG_POS_CONS = 3'd1;
	localparam logic [2:0] REG_WEIGHT_Q = 3'd2;
	localparam logic [2:0] REG_VAR_EN = 3'd3;
	localparam logic [2:0] REG_PYRO = 3'd4;

	typedef struct packed {
		logic [15:0] bin_size;
		logic        pos_cons;
		logic        weight_q;
		logic        var_en;
		logic        pyro;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] bin;
		logic [15:0] pbin;
		logic        pvalid;
		logic        rd_zero;
		logic [5:0]  sel;
		logic [21:0] vaddr;
		logic        ven;
		logic [2:0]  cls;
		logic        adj;
		logic        wrong;
		logic [6:0]  weight;
		logic [24:0] p_own;
		logic [24:0] p_prior;
	} job_t;

	localparam longint unsigned F0 = 16777216;
	localparam longint unsigned F1 = 13326616;
	localparam longint unsigned F2 = 10585708;
	localparam longint unsigned F3 = 8408526;
	localparam longint unsigned F4 = 6679130;
	localparam longint unsigned F5 = 5305422;
	localparam longint unsigned F6 = 4214246;
	localparam longint unsigned F7 = 3347495;
	localparam longint unsigned F8 = 2659010;
	localparam longint unsigned F9 = 2112126;
	localparam longint unsigned D0 = 1;
	localparam longint unsigned D1 = 10;
	localparam longint unsigned D2 = 100;
	localparam longint unsigned D3 = 1000;
	localparam longint unsigned D4 = 10000;
	localparam longint unsigned D5 = 100000;
	localparam longint unsigned D6 = 1000000;
	localparam longint unsigned D7 = 10000000;

	// q1.24 error probability, zero from q of 80 up
	localparam logic [24:0] PROB_TAB [0:79] = '{
		25'((F0+D0/2)/D0), 25'((F1+D0/2)/D0), 25'((F2+D0/2)/D0), 25'((F3+D0/2)/D0),
		25'((F4+D0/2)/D0), 25'((F5+D0/2)/D0), 25'((F6+D0/2)/D0), 25'((F7+D0/2)/D0),
		25'((F8+D0/2)/D0), 25'((F9+D0/2)/D0),
		25'((F0+D1/2)/D1), 25'((F1+D1/2)/D1), 25'((F2+D1/2)/D1), 25'((F3+D1/2)/D1),
		25'((F4+D1/2)/D1), 25'((F5+D1/2)/D1), 25'((F6+D1/2)/D1), 25'((F7+D1/2)/D1),
		25'((F8+D1/2)/D1), 25'((F9+D1/2)/D1),
		25'((F0+D2/2)/D2), 25'((F1+D2/2)/D2), 25'((F2+D2/2)/D2), 25'((F3+D2/2)/D2),
		25'((F4+D2/2)/D2), 25'((F5+D2/2)/D2), 25'((F6+D2/2)/D2), 25'((F7+D2/2)/D2),
		25'((F8+D2/2)/D2), 25'((F9+D2/2)/D2),
		25'((F0+D3/2)/D3), 25'((F1+D3/2)/D3), 25'((F2+D3/2)/D3), 25'((F3+D3/2)/D3),
		25'((F4+D3/2)/D3), 25'((F5+D3/2)/D3), 25'((F6+D3/2)/D3), 25'((F7+D3/2)/D3),
		25'((F8+D3/2)/D3), 25'((F9+D3/2)/D3),
		25'((F0+D4/2)/D4), 25'((F1+D4/2)/D4), 25'((F2+D4/2)/D4), 25'((F3+D4/2)/D4),
		25'((F4+D4/2)/D4), 25'((F5+D4/2)/D4), 25'((F6+D4/2)/D4), 25'((F7+D4/2)/D4),
		25'((F8+D4/2)/D4), 25'((F9+D4/2)/D4),
		25'((F0+D5/2)/D5), 25'((F1+D5/2)/D5), 25'((F2+D5/2)/D5), 25'((F3+D5/2)/D5),
		25'((F4+D5/2)/D5), 25'((F5+D5/2)/D5), 25'((F6+D5/2)/D5), 25'((F7+D5/2)/D5),
		25'((F8+D5/2)/D5), 25'((F9+D5/2)/D5),
		25'((F0+D6/2)/D6), 25'((F1+D6/2)/D6), 25'((F2+D6/2)/D6), 25'((F3+D6/2)/D6),
		25'((F4+D6/2)/D6), 25'((F5+D6/2)/D6), 25'((F6+D6/2)/D6), 25'((F7+D6/2)/D6),
		25'((F8+D6/2)/D6), 25'((F9+D6/2)/D6),
		25'((F0+D7/2)/D7), 25'((F1+D7/2)/D7), 25'((F2+D7/2)/D7), 25'((F3+D7/2)/D7),
		25'((F4+D7/2)/D7), 25'((F5+D7/2)/D7), 25'((F6+D7/2)/D7), 25'((F7+D7/2)/D7),
		25'((F8+D7/2)/D7), 25'((F9+D7/2)/D7)
	};

	function automatic logic [24:0] err_prob(input logic [6:0] q);
		err_prob = (q < 7'd80) ? PROB_TAB[q] : 25'd0;
	endfunction

	// bin * 48 + k
	function automatic logic [21:0] var_addr(input logic [15:0] bin, input logic [5:0] k);
		var_addr = {1'b0, bin, 5'b0} + {2'b0, bin, 4'b0} + {16'b0, k};
	endfunction

endpackage

@@ src/baeh_ram.sv @@
// baeh_ram: generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module baeh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ src/baeh_front.sv @@
// baeh_front: accepts items, finds the bin with a serial divider, classifies the pair
// and keeps the previous-pair state; depends on baeh_pkg
`timescale 1ns / 1ps

module baeh_front #(
	parameter int NUM_BINS = baeh_pkg::NUM_BINS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  baeh_pkg::cfg_t      cfg,
	input  logic                en,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [63:0]         s_tdata,
	input  logic [0:0]          s_tuser,
	output logic                push,
	output baeh_pkg::job_t      push_job,
	input  logic                full
);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_DIV = 2'd1;
	localparam logic [1:0] F_EVAL = 2'd2;
	localparam logic [1:0] F_PUSH = 2'd3;

	logic [1:0]  fstate_q;
	logic [15:0] dvd_q, rem_q, quot_q;
	logic [3:0]  cnt_q;
	logic [2:0]  rb_q, cb_q;
	logic [6:0]  qv_q;
	logic        pos_ge2_q;
	logic [2:0]  prev_rb_q, prev_cb_q;
	logic [6:0]  prev_qv_q;
	logic [1:0]  hp_q;
	baeh_pkg::job_t job_q;

	// input fields
	logic [15:0] in_rp, in_cp, in_pos;
	logic [2:0]  in_rb_raw, in_cb_raw, in_rb, in_cb;
	logic [6:0]  in_qv;
	logic [9:0]  in_bsel;
	logic [5:0]  in_sel;
	logic        in_skip, take;
	baeh_pkg::job_t rd_job, range_job, idle_job;

	assign in_rp = s_tdata[15:0];
	assign in_cp = s_tdata[31:16];
	assign in_rb_raw = s_tdata[34:32];
	assign in_cb_raw = s_tdata[37:35];
	assign in_qv = s_tdata[44:38];
	assign in_bsel = s_tdata[54:45];
	assign in_sel = s_tdata[60:55];
	assign in_rb = (in_rb_raw > baeh_pkg::BASE_GAP) ? baeh_pkg::BASE_GAP : in_rb_raw;
	assign in_cb = (in_cb_raw == baeh_pkg::BASE_NONE) ? baeh_pkg::BASE_GAP : in_cb_raw;
	assign in_pos = cfg.pos_cons ? in_cp : in_rp;
	assign in_skip = (in_cb == baeh_pkg::BASE_X) ||
		(in_cb == baeh_pkg::BASE_N && in_rb != baeh_pkg::BASE_GAP) ||
		(in_rb == baeh_pkg::BASE_N);

	assign s_tready = (fstate_q == F_IDLE) && en;
	assign take = s_tvalid && s_tready;

	always_comb begin
		rd_job = '0;
		rd_job.kind = baeh_pkg::JOB_READ;
		rd_job.bin = {6'b0, in_bsel};
		rd_job.sel = in_sel;
		rd_job.rd_zero = ({7'b0, in_bsel} >= 17'(NUM_BINS)) ||
			(in_sel > baeh_pkg::SEL_GLB_LAST);
		rd_job.vaddr = baeh_pkg::var_addr({6'b0, in_bsel},
			(in_sel >= baeh_pkg::SEL_VAR_FIRST && in_sel <= baeh_pkg::SEL_VAR_LAST) ?
			(in_sel - baeh_pkg::SEL_VAR_FIRST) : 6'd0);
	end

	always_comb begin
		range_job = '0;
		range_job.kind = baeh_pkg::JOB_NONE;
		range_job.cls = baeh_pkg::CLS_RANGE;
	end

	always_comb begin
		idle_job = range_job;
		if (s_tuser[0] == baeh_pkg::OP_READ) begin
			idle_job = rd_job;
		end else if (in_skip) begin
			idle_job = '0;
			idle_job.kind = baeh_pkg::JOB_SKIP;
			idle_job.cls = baeh_pkg::CLS_SKIP;
		end
	end

	// divider step
	logic [16:0] trial;
	logic        fits;
	logic [15:0] bs;
	assign bs = (cfg.bin_size == 16'd0) ? 16'd1 : cfg.bin_size;
	assign trial = {rem_q, dvd_q[15]};
	assign fits = trial >= {1'b0, bs};

	// evaluation of a divided pair
	logic        oor, hp1, adj, wrong, prior;
	logic [2:0]  cls;
	logic [5:0]  vk;
	logic [6:0]  qmin;
	baeh_pkg::job_t acc_job;

	assign oor = {1'b0, quot_q} >= 17'(NUM_BINS);
	assign hp1 = hp_q[0] | (rb_q == prev_rb_q);
	assign wrong = rb_q != cb_q;
	assign adj = cfg.pyro && (hp1 != hp_q[1]) && (prev_rb_q != prev_cb_q) &&
		(prev_rb_q != baeh_pkg::BASE_GAP) && (prev_cb_q != baeh_pkg::BASE_GAP);
	assign qmin = (qv_q < prev_qv_q) ? qv_q : prev_qv_q;

	always_comb begin
		if (rb_q == baeh_pkg::BASE_GAP) begin
			cls = baeh_pkg::CLS_DEL;
			vk = baeh_pkg::VAR_DEL_BASE + {3'b0, cb_q};
		end else if (cb_q == baeh_pkg::BASE_GAP) begin
			cls = baeh_pkg::CLS_INS;
			vk = baeh_pkg::VAR_INS_BASE + {3'b0, rb_q};
		end else begin
			cls = wrong ? baeh_pkg::CLS_SUB : baeh_pkg::CLS_MATCH;
			vk = {cb_q, 2'b0} + {1'b0, cb_q, 1'b0} + {3'b0, rb_q};
		end
	end

	assign prior = (cls == baeh_pkg::CLS_MATCH || cls == baeh_pkg::CLS_SUB) &&
		(prev_rb_q == baeh_pkg::BASE_GAP) && pos_ge2_q;

	always_comb begin
		acc_job = '0;
		acc_job.kind = baeh_pkg::JOB_ACC;
		acc_job.bin = quot_q;
		acc_job.pbin = (rem_q == 16'd0) ? (quot_q - 16'd1) : quot_q;
		acc_job.pvalid = prior;
		acc_job.vaddr = baeh_pkg::var_addr(quot_q, vk);
		acc_job.ven = cfg.var_en && (cls != baeh_pkg::CLS_MATCH);
		acc_job.cls = cls;
		acc_job.adj = adj;
		acc_job.wrong = wrong;
		acc_job.weight = cfg.weight_q ? qv_q : 7'd1;
		acc_job.p_own = baeh_pkg::err_prob(qv_q);
		acc_job.p_prior = baeh_pkg::err_prob(qmin);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fstate_q <= F_IDLE;
			cnt_q <= '0;
			prev_rb_q <= baeh_pkg::BASE_GAP;
			prev_cb_q <= baeh_pkg::BASE_NONE;
			prev_qv_q <= '0;
			hp_q <= '0;
		end else begin
			case (fstate_q)
				F_IDLE: begin
					if (take) begin
						rb_q <= in_rb;
						cb_q <= in_cb;
						qv_q <= in_qv;
						pos_ge2_q <= in_pos >= 16'd2;
						job_q <= idle_job;
						if (s_tuser[0] == baeh_pkg::OP_READ) begin
							fstate_q <= F_PUSH;
						end else if (in_skip) begin
							if (in_rb == prev_rb_q) begin
								hp_q[0] <= 1'b1;
							end
							fstate_q <= F_PUSH;
						end else if (in_pos == 16'd0) begin
							fstate_q <= F_PUSH;
						end else begin
							dvd_q <= in_pos - 16'd1;
							rem_q <= '0;
							cnt_q <= '0;
							fstate_q <= F_DIV;
						end
					end
				end
				F_DIV: begin
					rem_q <= fits ? 16'(trial - {1'b0, bs}) : trial[15:0];
					quot_q <= {quot_q[14:0], fits};
					dvd_q <= {dvd_q[14:0], 1'b0};
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						fstate_q <= F_EVAL;
					end
				end
				F_EVAL: begin
					job_q <= oor ? range_job : acc_job;
					if (!oor) begin
						prev_qv_q <= qv_q;
						prev_rb_q <= rb_q;
						prev_cb_q <= cb_q;
						hp_q <= {hp1, 1'b0};
					end
					fstate_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!full) begin
						fstate_q <= F_IDLE;
					end
				end
				default: fstate_q <= F_IDLE;
			endcase
		end
	end

	assign push = (fstate_q == F_PUSH) && !full;
	assign push_job = job_q;

endmodule

@@ src/baeh_queue.sv @@
// baeh_queue: two-entry job queue between the front and back parts
// depends on baeh_pkg
`timescale 1ns / 1ps

module baeh_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  baeh_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output baeh_pkg::job_t head,
	output logic           nonempty
);

	baeh_pkg::job_t slot_q [0:1];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_job;
		end
	end

	assign full = cnt_q == 2'd2;
	assign nonempty = cnt_q != 2'd0;
	assign head = slot_q[rp_q];

endmodule

@@ src/baeh_back.sv @@
// baeh_back: read-modify-write engine over the bin, probability and variant memories,
// global tallies, clearing pass and result register; depends on baeh_pkg, baeh_ram
`timescale 1ns / 1ps

module baeh_back #(
	parameter int NUM_BINS = baeh_pkg::NUM_BINS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           nonempty,
	input  baeh_pkg::job_t head,
	output logic           pop,
	output logic           clearing,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [63:0]    m_tdata
);

	localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int VAR_DEPTH = NUM_BINS * baeh_pkg::VAR_PER_BIN;
	localparam int VAR_AW = $clog2(VAR_DEPTH);
	localparam int CNT_W = 163;
	localparam int PRB_W = 80;

	localparam logic [2:0] B_CLR = 3'd0;
	localparam logic [2:0] B_IDLE = 3'd1;
	localparam logic [2:0] B_RD1 = 3'd2;
	localparam logic [2:0] B_WR1 = 3'd3;
	localparam logic [2:0] B_RD2 = 3'd4;
	localparam logic [2:0] B_WR2 = 3'd5;
	localparam logic [2:0] B_OUT = 3'd6;

	logic [2:0]        bstate_q;
	logic [VAR_AW-1:0] clr_q;
	baeh_pkg::job_t    job_q;
	logic [31:0]       glb_q [0:5];
	logic [47:0]       res_val_q;
	logic [9:0]        res_bin_q;
	logic [2:0]        res_cls_q;
	logic              res_adj_q;
	logic              m_valid_q;
	logic [63:0]       m_data_q;

	logic              c_we, p_we, v_we;
	logic [BIN_W-1:0]  c_waddr, c_raddr, p_waddr, p_raddr;
	logic [VAR_AW-1:0] v_waddr, v_raddr;
	logic [CNT_W-1:0]  c_wdata, c_rdata;
	logic [PRB_W-1:0]  p_wdata, p_rdata;
	logic [31:0]       v_wdata, v_rdata;

	baeh_ram #(.WIDTH(CNT_W), .DEPTH(NUM_BINS), .AW(BIN_W)) u_cnt_ram (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
		.raddr(c_raddr), .rdata(c_rdata)
	);
	baeh_ram #(.WIDTH(PRB_W), .DEPTH(NUM_BINS), .AW(BIN_W)) u_prb_ram (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rdata)
	);
	baeh_ram #(.WIDTH(32), .DEPTH(VAR_DEPTH), .AW(VAR_AW)) u_var_ram (
		.clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
		.raddr(v_raddr), .rdata(v_rdata)
	);

	// bin record fields
	logic [31:0] total, wrong_cnt, qcnt;
	logic [32:0] del, ins, sub;
	logic [47:0] psum;
	assign total = c_rdata[31:0];
	assign wrong_cnt = c_rdata[63:32];
	assign del = c_rdata[96:64];
	assign ins = c_rdata[129:97];
	assign sub = c_rdata[162:130];
	assign psum = p_rdata[47:0];
	assign qcnt = p_rdata[79:48];

	logic        is_sub, is_del, is_ins;
	logic [31:0] w32;
	assign is_sub = job_q.cls == baeh_pkg::CLS_SUB;
	assign is_del = job_q.cls == baeh_pkg::CLS_DEL;
	assign is_ins = job_q.cls == baeh_pkg::CLS_INS;
	assign w32 = {25'b0, job_q.weight};

	logic [31:0] n_total, n_wrong;
	logic [32:0] n_del, n_ins, n_sub;
	assign n_total = total + w32;
	assign n_wrong = job_q.wrong ? (wrong_cnt + w32) : wrong_cnt;
	assign n_del = del + {31'b0, is_del, job_q.adj};
	assign n_ins = ins + {31'b0, is_ins, job_q.adj};
	assign n_sub = sub + {31'b0, is_sub, 1'b0} - {31'b0, job_q.adj, 1'b0};

	always_comb begin
		c_we = 1'b0;
		p_we = 1'b0;
		v_we = 1'b0;
		c_waddr = BIN_W'(job_q.bin);
		c_raddr = BIN_W'(job_q.bin);
		c_wdata = {n_sub, n_ins, n_del, n_wrong, n_total};
		p_raddr = (bstate_q == B_RD1 && job_q.kind == baeh_pkg::JOB_ACC && job_q.pvalid) ?
			BIN_W'(job_q.pbin) : BIN_W'(job_q.bin);
		p_waddr = BIN_W'(job_q.bin);
		p_wdata = {qcnt + 32'd1, psum + {23'b0, job_q.p_own}};
		v_waddr = VAR_AW'(job_q.vaddr);
		v_raddr = VAR_AW'(job_q.vaddr);
		v_wdata = v_rdata + w32;
		case (bstate_q)
			B_CLR: begin
				c_we = clr_q < VAR_AW'(NUM_BINS);
				p_we = c_we;
				v_we = 1'b1;
				c_waddr = BIN_W'(clr_q);
				p_waddr = BIN_W'(clr_q);
				v_waddr = clr_q;
				c_wdata = '0;
				p_wdata = '0;
				v_wdata = '0;
			end
			B_WR1: begin
				if (job_q.kind == baeh_pkg::JOB_ACC) begin
					c_we = 1'b1;
					v_we = job_q.ven;
					p_we = job_q.pvalid;
					p_waddr = BIN_W'(job_q.pbin);
					p_wdata = {qcnt + 32'd1, psum + {23'b0, job_q.p_prior}};
				end
			end
			B_WR2: begin
				p_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// counter read-back
	logic [47:0] rd_val;
	logic [2:0]  gidx;
	assign gidx = 3'(job_q.sel - baeh_pkg::SEL_GLB_FIRST);

	always_comb begin
		case (job_q.sel) inside
			baeh_pkg::SEL_TOTAL: rd_val = {16'b0, total};
			baeh_pkg::SEL_WRONG: rd_val = {16'b0, wrong_cnt};
			baeh_pkg::SEL_DEL: rd_val = {15'b0, del};
			baeh_pkg::SEL_INS: rd_val = {15'b0, ins};
			baeh_pkg::SEL_SUB: rd_val = {{15{sub[32]}}, sub};
			baeh_pkg::SEL_PSUM: rd_val = psum;
			baeh_pkg::SEL_QCNT: rd_val = {16'b0, qcnt};
			[baeh_pkg::SEL_VAR_FIRST:baeh_pkg::SEL_VAR_LAST]: rd_val = {16'b0, v_rdata};
			[baeh_pkg::SEL_GLB_FIRST:baeh_pkg::SEL_GLB_LAST]: rd_val = {16'b0, glb_q[gidx]};
			default: rd_val = '0;
		endcase
		if (job_q.rd_zero) begin
			rd_val = '0;
		end
	end

	logic [31:0] bin_next;
	assign bin_next = {16'b0, job_q.bin} + 32'd1;

	assign pop = (bstate_q == B_IDLE) && nonempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bstate_q <= B_CLR;
			clr_q <= '0;
			m_valid_q <= 1'b0;
			for (int i = 0; i < 6; i++) begin
				glb_q[i] <= '0;
			end
		end else begin
			if (bstate_q == B_OUT && (!m_valid_q || m_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (bstate_q)
				B_CLR: begin
					clr_q <= clr_q + VAR_AW'(1);
					if (clr_q == VAR_AW'(VAR_DEPTH - 1)) begin
						bstate_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (nonempty) begin
						job_q <= head;
						res_val_q <= '0;
						res_bin_q <= (head.kind == baeh_pkg::JOB_SKIP ||
							head.kind == baeh_pkg::JOB_NONE) ? 10'd0 : head.bin[9:0];
						res_cls_q <= head.cls;
						res_adj_q <= head.adj;
						case (head.kind)
							baeh_pkg::JOB_SKIP: begin
								glb_q[0] <= glb_q[0] + 32'd1;
								bstate_q <= B_OUT;
							end
							baeh_pkg::JOB_NONE: bstate_q <= B_OUT;
							default: bstate_q <= B_RD1;
						endcase
					end
				end
				B_RD1: bstate_q <= B_WR1;
				B_WR1: begin
					if (job_q.kind == baeh_pkg::JOB_READ) begin
						res_val_q <= rd_val;
						bstate_q <= B_OUT;
					end else begin
						glb_q[0] <= glb_q[0] + 32'd1;
						if (!is_del && !is_ins) begin
							glb_q[1] <= glb_q[1] + 32'd1;
						end
						if (is_ins) begin
							glb_q[2] <= glb_q[2] + 32'd1;
						end
						if (is_del) begin
							glb_q[3] <= glb_q[3] + 32'd1;
						end
						if (is_sub) begin
							glb_q[4] <= glb_q[4] + 32'd1;
						end
						if (bin_next > glb_q[5]) begin
							glb_q[5] <= bin_next;
						end
						bstate_q <= B_RD2;
					end
				end
				B_RD2: bstate_q <= B_WR2;
				B_WR2: bstate_q <= B_OUT;
				B_OUT: begin
					if (!m_valid_q || m_tready) begin
						m_data_q <= {2'b0, res_adj_q, res_cls_q, res_bin_q, res_val_q};
						bstate_q <= B_IDLE;
					end
				end
				default: bstate_q <= B_IDLE;
			endcase
		end
	end

	assign clearing = bstate_q == B_CLR;
	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;

endmodule

@@ src/binned_alignment_error_histogram_core.sv @@
// binned_alignment_error_histogram_core: top level with configuration registers
// depends on baeh_pkg, baeh_front, baeh_queue, baeh_back
`timescale 1ns / 1ps

// Usage
// s_* carries one request per accept: s_tuser[0] is the operation (0 accumulate
// one aligned base pair, 1 read one counter), s_tdata the pair and read fields.
// m_* returns exactly one result per request, in request order.
// cfg_* writes one register by index (0 bin_size, 1 position_from_consensus,
// 2 weight_by_quality, 3 variant_tables, 4 pyro_mode); write only while idle.
// Flow: a non-skipped accumulate at a nonzero position passes through the front's
// one-bit-per-cycle bin divider and then two read-modify-write passes in the back
// (the bin and variant memories plus, for a prior, the prior bin's probability,
// then its own bin's probability); a read skips the divider and takes one pass.
// The front takes a new request only after it has pushed the previous one.
// Reset: the back sweeps every memory to zero, one entry per cycle through the
// NUM_BINS*48 variant entries (49152 at the default), with s_tready low meanwhile;
// configuration writes are taken at any time.
// Stall: a held m_tready leaves the result in the output register while the
// two-entry queue and the front keep taking requests until the queue fills.

module binned_alignment_error_histogram_core #(
	parameter int NUM_BINS = baeh_pkg::NUM_BINS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// read_position, consensus_position, read_base, consensus_base, quality,
	// bin_select, counter_select
	input  logic [63:0] s_tdata,
	// operation
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// read_value, bin_index, base_class, pyro_adjusted
	output logic [63:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	baeh_pkg::cfg_t cfg_q;
	baeh_pkg::job_t push_job, head;
	logic push, full, pop, nonempty, clearing;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{bin_size: 16'd1, pos_cons: 1'b0, weight_q: 1'b0, var_en: 1'b0,
				pyro: 1'b0};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				baeh_pkg::REG_BIN_SIZE: cfg_q.bin_size <= cfg_data;
				baeh_pkg::REG_POS_CONS: cfg_q.pos_cons <= cfg_data[0];
				baeh_pkg::REG_WEIGHT_Q: cfg_q.weight_q <= cfg_data[0];
				baeh_pkg::REG_VAR_EN: cfg_q.var_en <= cfg_data[0];
				baeh_pkg::REG_PYRO: cfg_q.pyro <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	baeh_front #(.NUM_BINS(NUM_BINS)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .en(!clearing),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.push(push), .push_job(push_job), .full(full)
	);

	baeh_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_job(push_job), .full(full),
		.pop(pop), .head(head), .nonempty(nonempty)
	);

	baeh_back #(.NUM_BINS(NUM_BINS)) u_back (
		.clk(clk), .arst_n(arst_n), .nonempty(nonempty), .head(head), .pop(pop),
		.clearing(clearing), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

endmodule

@@ src/baeh_checker.sv @@
// baeh_checker: port-level assertions on the result channel, bound to the top level
// depends on binned_alignment_error_histogram_core
`timescale 1ns / 1ps

module baeh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[60:58] == 3'd4 || m_tdata[60:58] == 3'd5) |->
		m_tdata[57:48] == 10'd0 && m_tdata[47:0] == 48'd0 && !m_tdata[61])
		else $error("skipped or out of range result carries data");

	a_adj: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[61] |-> m_tdata[47:0] == 48'd0 && m_tdata[60:58] <= 3'd3)
		else $error("pyro adjust on a result that is not an accumulate");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[63:62] == 2'd0 && m_tdata[60:58] <= 3'd5)
		else $error("bad class or padding");

endmodule

bind binned_alignment_error_histogram_core baeh_checker u_baeh_checker (.*);
